// ===== hw/rtl/itp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instruction trace profiler package
// Shared constants, operation and table codes, and the structs passed
// between the front end, the histogram banks and the top level.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int DEF_HIST_BINS  = 128;
   localparam int DEF_BIN_WIDTH  = 32;
   localparam int DATA_W         = 48;
   localparam int ADDR_W         = 64;
   localparam int NUM_SCALARS    = 10;
   localparam int RSP_FIFO_DEPTH = 8;

   localparam logic [1:0] OP_RECORD = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   localparam logic [1:0] TBL_MICRO  = 2'd0;
   localparam logic [1:0] TBL_SIZE   = 2'd1;
   localparam logic [1:0] TBL_BRANCH = 2'd2;
   localparam logic [1:0] TBL_SCALAR = 2'd3;

   localparam logic [1:0] COND_NONE   = 2'd0;
   localparam logic [1:0] COND_READS  = 2'd1;
   localparam logic [1:0] COND_WRITES = 2'd2;

   localparam logic [1:0] MEM_LOAD  = 2'd1;
   localparam logic [1:0] MEM_STORE = 2'd2;

   localparam int SC_MICRO  = 0;
   localparam int SC_MACRO  = 1;
   localparam int SC_SIZE   = 2;
   localparam int SC_BRANCH = 3;
   localparam int SC_LOAD   = 4;
   localparam int SC_STORE  = 5;
   localparam int SC_UBR    = 6;
   localparam int SC_CBR    = 7;
   localparam int SC_OTHER  = 8;
   localparam int SC_FUSE   = 9;

   typedef struct packed {
      logic bump;
      logic rd;
   } hist_cmd_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        tbl;
      logic              in_range;
      logic [DATA_W-1:0] scalar;
   } rd_info_type;

endpackage

// ===== hw/rtl/itp_hist_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram bank
// One bin memory with a registered read. Bumps are read, incremented
// and written back; the last write is forwarded to a read of the same
// bin issued at the same edge. Per-bin valid bits stand in for the
// cleared reset contents.
// ----------------------------------------------------------------------------
module itp_hist_bank #(
   parameter int HIST_BINS = itp_pkg::DEF_HIST_BINS,
   parameter int BIN_WIDTH = itp_pkg::DEF_BIN_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  itp_pkg::hist_cmd_type      cmd,
   input  logic [$clog2(HIST_BINS)-1:0] addr,
   output logic [BIN_WIDTH-1:0]       value
);

   localparam int AW = $clog2(HIST_BINS);

   logic [BIN_WIDTH-1:0] mem_ff [HIST_BINS];
   logic [HIST_BINS-1:0] valid_ff;
   logic [BIN_WIDTH-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic                 bump_ff;
   logic [AW-1:0]        addr_ff;
   logic                 wr_en_ff;
   logic [AW-1:0]        wr_addr_ff;
   logic [BIN_WIDTH-1:0] wr_data_ff;
   logic [BIN_WIDTH-1:0] cur_val;
   logic [BIN_WIDTH-1:0] next_val;

   always_comb begin
      if (wr_en_ff && (wr_addr_ff == addr_ff)) begin
         cur_val = wr_data_ff;
      end else if (rd_valid_ff) begin
         cur_val = rd_data_ff;
      end else begin
         cur_val = '0;
      end
      next_val = cur_val + BIN_WIDTH'(1);
   end

   assign value = cur_val;

   always_ff @(posedge clock) begin
      if (cmd.bump || cmd.rd) begin
         rd_data_ff <= mem_ff[addr];
      end
      if (bump_ff) begin
         mem_ff[addr_ff] <= next_val;
      end
      addr_ff    <= addr;
      wr_addr_ff <= addr_ff;
      wr_data_ff <= next_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         bump_ff     <= 1'b0;
         wr_en_ff    <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         bump_ff  <= cmd.bump;
         wr_en_ff <= bump_ff;
         if (bump_ff) begin
            valid_ff[addr_ff] <= 1'b1;
         end
         if (cmd.bump || cmd.rd) begin
            rd_valid_ff <= valid_ff[addr];
         end
      end
   end

   a_written_bin_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en_ff |-> valid_ff[wr_addr_ff])
      else $error("written bin not marked valid");

endmodule

// ===== hw/rtl/itp_rsp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response queue
// Small register queue holding read results until the receiver takes them.
// ----------------------------------------------------------------------------
module itp_rsp_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [itp_pkg::DATA_W-1:0]  push_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [itp_pkg::DATA_W-1:0]  out_data
);

   localparam int PW = $clog2(itp_pkg::RSP_FIFO_DEPTH);

   logic [itp_pkg::DATA_W-1:0] slot_ff [itp_pkg::RSP_FIFO_DEPTH];
   logic [PW-1:0]              wr_ptr_ff;
   logic [PW-1:0]              rd_ptr_ff;
   logic [PW:0]                count_ff;
   logic [PW:0]                count_in;
   logic                       pop;

   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != (PW+1)'(itp_pkg::RSP_FIFO_DEPTH)))
      else $error("response queue overflow");

endmodule

// ===== hw/rtl/itp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Profiler front end
// Decodes each beat, tracks the previous micro index and flag use, computes
// size and branch distance bins over three stages, keeps the scalar
// counters, and issues bump or read commands to the histogram banks.
// ----------------------------------------------------------------------------
module itp_front #(
   parameter int HIST_BINS = itp_pkg::DEF_HIST_BINS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          acc,
   input  logic [1:0]                    in_op,
   input  logic [6:0]                    in_micro_index,
   input  logic [itp_pkg::ADDR_W-1:0]    in_instr_address,
   input  logic [itp_pkg::ADDR_W-1:0]    in_fallthrough_pc,
   input  logic [itp_pkg::ADDR_W-1:0]    in_branch_target,
   input  logic [1:0]                    in_cond_kind,
   input  logic [1:0]                    in_mem_kind,
   input  logic [1:0]                    in_read_table,
   input  logic [6:0]                    in_read_index,
   output itp_pkg::hist_cmd_type         micro_cmd,
   output logic [$clog2(HIST_BINS)-1:0]  micro_addr,
   output itp_pkg::hist_cmd_type         size_cmd,
   output logic [$clog2(HIST_BINS)-1:0]  size_addr,
   output itp_pkg::hist_cmd_type         branch_cmd,
   output logic [$clog2(HIST_BINS)-1:0]  branch_addr,
   output itp_pkg::rd_info_type          rd_info
);

   localparam int AW = $clog2(HIST_BINS);
   localparam int DW = itp_pkg::DATA_W;
   localparam int XW = itp_pkg::ADDR_W;
   localparam int NS = itp_pkg::NUM_SCALARS;

   typedef struct packed {
      logic       is_record;
      logic       is_read;
      logic       first;
      logic       is_branch;
      logic       micro_bump;
      logic       fuse;
      logic [1:0] cond;
      logic [1:0] mem;
      logic [1:0] tbl;
      logic [6:0] idx;
   } stage_ctrl_type;

   // stage 0: decode and history
   logic [6:0]     last_micro_ff, last_micro_in;
   logic [1:0]     last_cond_ff, last_cond_in;
   stage_ctrl_type s0_ctrl;
   logic [AW-1:0]  s0_micro_bin;

   // stage 1: size and distance
   stage_ctrl_type s1_ctrl_ff;
   logic [AW-1:0]  s1_micro_bin_ff;
   logic [XW-1:0]  s1_addr_ff, s1_fall_ff, s1_target_ff;
   logic [XW-1:0]  s1_size, s1_dist;
   logic [AW-1:0]  s1_size_bin;

   // stage 2: group encode and scalar counters
   stage_ctrl_type        s2_ctrl_ff;
   logic [AW-1:0]         s2_micro_bin_ff, s2_size_bin_ff;
   logic [DW-1:0]         s2_size_ff;
   logic [XW-1:0]         s2_dist_ff;
   logic [7:0]            s2_grp_nz;
   logic [7:0][2:0]       s2_grp_pos;
   logic [NS-1:0][DW-1:0] sc_ff, sc_in, sc_add;
   logic [DW-1:0]         s2_scalar;

   // stage 3: branch bin and bank commands
   stage_ctrl_type  s3_ctrl_ff;
   logic [AW-1:0]   s3_micro_bin_ff, s3_size_bin_ff;
   logic [7:0]      s3_grp_nz_ff;
   logic [7:0][2:0] s3_grp_pos_ff;
   logic [DW-1:0]   s3_scalar_ff;
   logic [2:0]      s3_hi_grp;
   logic [5:0]      s3_log2;
   logic [6:0]      s3_bin_full;
   logic [AW-1:0]   s3_branch_bin;
   logic [AW-1:0]   s3_idx_addr;
   logic            s3_in_range;

   always_comb begin
      s0_ctrl.is_record  = acc && (in_op == itp_pkg::OP_RECORD);
      s0_ctrl.is_read    = acc && (in_op == itp_pkg::OP_READ);
      s0_ctrl.first      = in_micro_index == 7'd1;
      s0_ctrl.is_branch  = in_branch_target != '0;
      s0_ctrl.micro_bump = (s0_ctrl.is_record && s0_ctrl.first) ||
                           (acc && (in_op == itp_pkg::OP_FLUSH));
      s0_ctrl.fuse       = s0_ctrl.is_record && (last_cond_ff == itp_pkg::COND_WRITES) &&
                           s0_ctrl.is_branch && (in_cond_kind == itp_pkg::COND_READS);
      s0_ctrl.cond       = in_cond_kind;
      s0_ctrl.mem        = in_mem_kind;
      s0_ctrl.tbl        = in_read_table;
      s0_ctrl.idx        = in_read_index;
      if (int'(last_micro_ff) > HIST_BINS - 1) begin
         s0_micro_bin = AW'(HIST_BINS - 1);
      end else begin
         s0_micro_bin = AW'(last_micro_ff);
      end
      last_micro_in = last_micro_ff;
      last_cond_in  = last_cond_ff;
      if (s0_ctrl.is_record) begin
         last_micro_in = in_micro_index;
         last_cond_in  = in_cond_kind;
      end else if (acc && (in_op == itp_pkg::OP_FLUSH)) begin
         last_micro_in = '0;
      end
   end

   always_comb begin
      s1_size = s1_fall_ff - s1_addr_ff;
      if (s1_addr_ff >= s1_target_ff) begin
         s1_dist = s1_addr_ff - s1_target_ff;
      end else begin
         s1_dist = s1_target_ff - s1_addr_ff;
      end
      if (s1_size > XW'(HIST_BINS - 1)) begin
         s1_size_bin = AW'(HIST_BINS - 1);
      end else begin
         s1_size_bin = s1_size[AW-1:0];
      end
   end

   always_comb begin
      for (int g = 0; g < 8; g++) begin
         s2_grp_nz[g]  = |s2_dist_ff[g*8 +: 8];
         s2_grp_pos[g] = '0;
         for (int b = 0; b < 8; b++) begin
            if (s2_dist_ff[g*8 + b]) begin
               s2_grp_pos[g] = 3'(b);
            end
         end
      end
   end

   always_comb begin
      sc_add = '0;
      if (s2_ctrl_ff.is_record) begin
         sc_add[itp_pkg::SC_MICRO] = DW'(1);
         if (s2_ctrl_ff.first) begin
            sc_add[itp_pkg::SC_MACRO] = DW'(1);
            sc_add[itp_pkg::SC_SIZE]  = s2_size_ff;
         end
         if (s2_ctrl_ff.is_branch) begin
            sc_add[itp_pkg::SC_BRANCH] = DW'(1);
         end
         if (s2_ctrl_ff.mem == itp_pkg::MEM_LOAD) begin
            sc_add[itp_pkg::SC_LOAD] = DW'(1);
         end else if (s2_ctrl_ff.mem == itp_pkg::MEM_STORE) begin
            sc_add[itp_pkg::SC_STORE] = DW'(1);
         end else if (s2_ctrl_ff.is_branch && (s2_ctrl_ff.cond == itp_pkg::COND_NONE)) begin
            sc_add[itp_pkg::SC_UBR] = DW'(1);
         end else if (s2_ctrl_ff.is_branch && (s2_ctrl_ff.cond == itp_pkg::COND_READS)) begin
            sc_add[itp_pkg::SC_CBR] = DW'(1);
         end else begin
            sc_add[itp_pkg::SC_OTHER] = DW'(1);
         end
         if (s2_ctrl_ff.fuse) begin
            sc_add[itp_pkg::SC_FUSE] = DW'(1);
         end
      end
      for (int n = 0; n < NS; n++) begin
         sc_in[n] = sc_ff[n] + sc_add[n];
      end
      s2_scalar = '0;
      if (int'(s2_ctrl_ff.idx) < NS) begin
         s2_scalar = sc_ff[s2_ctrl_ff.idx[3:0]];
      end
   end

   always_comb begin
      s3_hi_grp = '0;
      for (int g = 0; g < 8; g++) begin
         if (s3_grp_nz_ff[g]) begin
            s3_hi_grp = 3'(g);
         end
      end
      s3_log2 = {s3_hi_grp, s3_grp_pos_ff[s3_hi_grp]};
      if (|s3_grp_nz_ff) begin
         s3_bin_full = 7'(s3_log2) + 7'd2;
      end else begin
         s3_bin_full = '0;
      end
      if (int'(s3_bin_full) > HIST_BINS - 1) begin
         s3_branch_bin = AW'(HIST_BINS - 1);
      end else begin
         s3_branch_bin = AW'(s3_bin_full);
      end
      s3_in_range = int'(s3_ctrl_ff.idx) < HIST_BINS;
      s3_idx_addr = AW'(s3_ctrl_ff.idx);
   end

   always_comb begin
      micro_cmd.bump  = s3_ctrl_ff.micro_bump;
      micro_cmd.rd    = s3_ctrl_ff.is_read && (s3_ctrl_ff.tbl == itp_pkg::TBL_MICRO) &&
                        s3_in_range;
      micro_addr      = s3_ctrl_ff.micro_bump ? s3_micro_bin_ff : s3_idx_addr;
      size_cmd.bump   = s3_ctrl_ff.is_record && s3_ctrl_ff.first;
      size_cmd.rd     = s3_ctrl_ff.is_read && (s3_ctrl_ff.tbl == itp_pkg::TBL_SIZE) &&
                        s3_in_range;
      size_addr       = size_cmd.bump ? s3_size_bin_ff : s3_idx_addr;
      branch_cmd.bump = s3_ctrl_ff.is_record && s3_ctrl_ff.is_branch;
      branch_cmd.rd   = s3_ctrl_ff.is_read && (s3_ctrl_ff.tbl == itp_pkg::TBL_BRANCH) &&
                        s3_in_range;
      branch_addr     = branch_cmd.bump ? s3_branch_bin : s3_idx_addr;
      rd_info.valid    = s3_ctrl_ff.is_read;
      rd_info.tbl      = s3_ctrl_ff.tbl;
      rd_info.in_range = s3_in_range;
      rd_info.scalar   = s3_scalar_ff;
   end

   always_ff @(posedge clock) begin
      s1_micro_bin_ff <= s0_micro_bin;
      s1_addr_ff      <= in_instr_address;
      s1_fall_ff      <= in_fallthrough_pc;
      s1_target_ff    <= in_branch_target;
      s2_micro_bin_ff <= s1_micro_bin_ff;
      s2_size_bin_ff  <= s1_size_bin;
      s2_size_ff      <= s1_size[DW-1:0];
      s2_dist_ff      <= s1_dist;
      s3_micro_bin_ff <= s2_micro_bin_ff;
      s3_size_bin_ff  <= s2_size_bin_ff;
      s3_grp_nz_ff    <= s2_grp_nz;
      s3_grp_pos_ff   <= s2_grp_pos;
      s3_scalar_ff    <= s2_scalar;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_micro_ff <= '0;
         last_cond_ff  <= itp_pkg::COND_NONE;
         s1_ctrl_ff    <= '0;
         s2_ctrl_ff    <= '0;
         s3_ctrl_ff    <= '0;
         sc_ff         <= '0;
      end else begin
         last_micro_ff <= last_micro_in;
         last_cond_ff  <= last_cond_in;
         s1_ctrl_ff    <= s0_ctrl;
         s2_ctrl_ff    <= s1_ctrl_ff;
         s3_ctrl_ff    <= s2_ctrl_ff;
         sc_ff         <= sc_in;
      end
   end

endmodule

// ===== hw/rtl/instruction_trace_profiler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instruction trace profiler core
// Profiles a retired micro-op trace into three bin histograms and ten
// 48-bit scalar counters, and returns counter values on read beats.
//
// The req_ channel carries one beat per trace record, read or flush, and
// is accepted on req_valid && req_ready. Only read beats produce a beat on
// the rsp_ channel, carrying rsp_read_data, in request order.
// One beat is accepted per cycle while req_ready is high. A read's result
// is offered on rsp_ once the front-end stages have computed the bins, the
// bin memories have registered the read data and the response queue holds it.
// Histogram bumps are read-modify-write with forwarding of the previous
// write, so back-to-back updates of one bin need no interlock.
// Read results wait in an eight-entry queue; req_ready drops while eight
// reads are outstanding, so a stalled receiver stalls the sender only
// after that many reads. Trace records and flushes never wait otherwise.
// Reset clears the scalar counters, and the histograms at once through
// per-bin valid bits; the block accepts beats on the first cycle after reset.
// ----------------------------------------------------------------------------
module instruction_trace_profiler_core #(
   parameter int HIST_BINS = itp_pkg::DEF_HIST_BINS,
   parameter int BIN_WIDTH = itp_pkg::DEF_BIN_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [6:0]                  req_micro_index,
   input  logic [itp_pkg::ADDR_W-1:0]  req_instr_address,
   input  logic [itp_pkg::ADDR_W-1:0]  req_fallthrough_pc,
   input  logic [itp_pkg::ADDR_W-1:0]  req_branch_target,
   input  logic [1:0]                  req_cond_kind,
   input  logic [1:0]                  req_mem_kind,
   input  logic [1:0]                  req_read_table,
   input  logic [6:0]                  req_read_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [itp_pkg::DATA_W-1:0]  rsp_read_data
);

   localparam int AW = $clog2(HIST_BINS);
   localparam int PW = $clog2(itp_pkg::RSP_FIFO_DEPTH);
   localparam int DW = itp_pkg::DATA_W;

   logic                  acc;
   logic                  rd_acc;
   logic                  pop;
   logic [PW:0]           pending_ff, pending_in;
   itp_pkg::hist_cmd_type micro_cmd, size_cmd, branch_cmd;
   logic [AW-1:0]         micro_addr, size_addr, branch_addr;
   logic [BIN_WIDTH-1:0]  micro_val, size_val, branch_val;
   itp_pkg::rd_info_type  rd_info, s4_info_ff;
   logic [DW-1:0]         push_data;

   assign acc        = req_valid && req_ready;
   assign rd_acc     = acc && (req_op == itp_pkg::OP_READ);
   assign pop        = rsp_valid && rsp_ready;
   assign req_ready  = pending_ff < (PW+1)'(itp_pkg::RSP_FIFO_DEPTH);
   assign pending_in = pending_ff + (PW+1)'(rd_acc) - (PW+1)'(pop);

   itp_front #(
      .HIST_BINS (HIST_BINS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .acc               (acc),
      .in_op             (req_op),
      .in_micro_index    (req_micro_index),
      .in_instr_address  (req_instr_address),
      .in_fallthrough_pc (req_fallthrough_pc),
      .in_branch_target  (req_branch_target),
      .in_cond_kind      (req_cond_kind),
      .in_mem_kind       (req_mem_kind),
      .in_read_table     (req_read_table),
      .in_read_index     (req_read_index),
      .micro_cmd         (micro_cmd),
      .micro_addr        (micro_addr),
      .size_cmd          (size_cmd),
      .size_addr         (size_addr),
      .branch_cmd        (branch_cmd),
      .branch_addr       (branch_addr),
      .rd_info           (rd_info)
   );

   itp_hist_bank #(
      .HIST_BINS (HIST_BINS),
      .BIN_WIDTH (BIN_WIDTH)
   ) u_micro_bank (
      .clock (clock),
      .reset (reset),
      .cmd   (micro_cmd),
      .addr  (micro_addr),
      .value (micro_val)
   );

   itp_hist_bank #(
      .HIST_BINS (HIST_BINS),
      .BIN_WIDTH (BIN_WIDTH)
   ) u_size_bank (
      .clock (clock),
      .reset (reset),
      .cmd   (size_cmd),
      .addr  (size_addr),
      .value (size_val)
   );

   itp_hist_bank #(
      .HIST_BINS (HIST_BINS),
      .BIN_WIDTH (BIN_WIDTH)
   ) u_branch_bank (
      .clock (clock),
      .reset (reset),
      .cmd   (branch_cmd),
      .addr  (branch_addr),
      .value (branch_val)
   );

   always_comb begin
      case (s4_info_ff.tbl)
         itp_pkg::TBL_MICRO:  push_data = DW'(micro_val);
         itp_pkg::TBL_SIZE:   push_data = DW'(size_val);
         itp_pkg::TBL_BRANCH: push_data = DW'(branch_val);
         default:             push_data = s4_info_ff.scalar;
      endcase
      if ((s4_info_ff.tbl != itp_pkg::TBL_SCALAR) && !s4_info_ff.in_range) begin
         push_data = '0;
      end
   end

   itp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s4_info_ff.valid),
      .push_data (push_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         s4_info_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         s4_info_ff <= rd_info;
      end
   end

   a_pending_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= (PW+1)'(itp_pkg::RSP_FIFO_DEPTH))
      else $error("outstanding read count exceeds queue depth");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0))
      else $error("response offered with no outstanding read");

endmodule

// ===== sim/tb_instruction_trace_profiler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instruction trace profiler core testbench
// Feeds directed and random trace, read and flush beats through the req_
// channel with bursty traffic, and keeps a shadow copy of every histogram
// and scalar counter. Each read beat's expected value is queued when the
// beat is accepted and checked against rsp_read_data under random stalls.
// ----------------------------------------------------------------------------
module tb_instruction_trace_profiler_core;

   localparam int          BINS         = itp_pkg::DEF_HIST_BINS;
   localparam int          BIN_W        = itp_pkg::DEF_BIN_WIDTH;
   localparam int          AW64         = itp_pkg::ADDR_W;
   localparam int          DW           = itp_pkg::DATA_W;
   localparam int          NSC          = itp_pkg::NUM_SCALARS;
   localparam int          RANDOM_BEATS = 1400;
   localparam int          IDLE_LIMIT   = 2000;
   localparam int          DRAIN_CYCLES = 12;
   localparam logic [1:0]  OP_SPARE     = 2'd3;
   localparam logic [1:0]  COND_OTHER   = 2'd3;
   localparam logic [1:0]  MEM_NONE     = 2'd0;
   localparam logic [1:0]  MEM_SPARE    = 2'd3;

   typedef struct {
      logic [1:0]      op;
      logic [6:0]      micro_index;
      logic [AW64-1:0] instr_address;
      logic [AW64-1:0] fallthrough_pc;
      logic [AW64-1:0] branch_target;
      logic [1:0]      cond_kind;
      logic [1:0]      mem_kind;
      logic [1:0]      read_table;
      logic [6:0]      read_index;
   } trace_beat_type;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_ready;
   logic [1:0]          req_op             = '0;
   logic [6:0]          req_micro_index    = '0;
   logic [AW64-1:0]     req_instr_address  = '0;
   logic [AW64-1:0]     req_fallthrough_pc = '0;
   logic [AW64-1:0]     req_branch_target  = '0;
   logic [1:0]          req_cond_kind      = '0;
   logic [1:0]          req_mem_kind       = '0;
   logic [1:0]          req_read_table     = '0;
   logic [6:0]          req_read_index     = '0;
   logic                rsp_valid;
   logic                rsp_ready          = 1'b0;
   logic [DW-1:0]       rsp_read_data;

   logic [BIN_W-1:0]    micro_bins  [BINS];
   logic [BIN_W-1:0]    size_bins   [BINS];
   logic [BIN_W-1:0]    branch_bins [BINS];
   logic [DW-1:0]       scalar_count [NSC];
   logic [6:0]          last_micro;
   logic [1:0]          last_cond;

   trace_beat_type      pending_beats [$];
   logic [DW-1:0]       expected_read_data [$];
   trace_beat_type      current_beat;

   int                  total_beats;
   int                  beats_accepted;
   int                  reads_checked;
   int                  mismatches;
   int                  burst_left;
   int                  gap_left;
   int                  stall_mode;
   int                  stall_phase_left;
   int                  idle_cycles;

   instruction_trace_profiler_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_micro_index    (req_micro_index),
      .req_instr_address  (req_instr_address),
      .req_fallthrough_pc (req_fallthrough_pc),
      .req_branch_target  (req_branch_target),
      .req_cond_kind      (req_cond_kind),
      .req_mem_kind       (req_mem_kind),
      .req_read_table     (req_read_table),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_data      (rsp_read_data)
   );

   always #2 clock = ~clock;

   function automatic int clamp_bin(input logic [63:0] idx);
      return (idx > BINS - 1) ? BINS - 1 : int'(idx);
   endfunction

   function automatic void profile_beat(input trace_beat_type b);
      logic [63:0]   size;
      logic [63:0]   distance;
      logic [DW-1:0] value;
      int            bin;
      int            i;
      bit            is_branch;
      case (b.op)
         itp_pkg::OP_RECORD: begin
            is_branch = (b.branch_target != '0);
            scalar_count[itp_pkg::SC_MICRO] += 1;
            if (b.micro_index == 7'd1) begin
               size = b.fallthrough_pc - b.instr_address;
               scalar_count[itp_pkg::SC_MACRO] += 1;
               micro_bins[clamp_bin(64'(last_micro))] += 1;
               size_bins[clamp_bin(size)] += 1;
               scalar_count[itp_pkg::SC_SIZE] += size[DW-1:0];
            end
            last_micro = b.micro_index;
            if (is_branch) begin
               distance = (b.instr_address >= b.branch_target) ?
                          b.instr_address - b.branch_target :
                          b.branch_target - b.instr_address;
               bin = 0;
               if (distance != '0) begin
                  bin = 2;
                  for (i = 1; i < 64; i++)
                     if (distance[i]) bin = 2 + i;
               end
               branch_bins[clamp_bin(64'(bin))] += 1;
               scalar_count[itp_pkg::SC_BRANCH] += 1;
            end
            if (b.mem_kind == itp_pkg::MEM_LOAD)
               scalar_count[itp_pkg::SC_LOAD] += 1;
            else if (b.mem_kind == itp_pkg::MEM_STORE)
               scalar_count[itp_pkg::SC_STORE] += 1;
            else if (is_branch && b.cond_kind == itp_pkg::COND_NONE)
               scalar_count[itp_pkg::SC_UBR] += 1;
            else if (is_branch && b.cond_kind == itp_pkg::COND_READS)
               scalar_count[itp_pkg::SC_CBR] += 1;
            else
               scalar_count[itp_pkg::SC_OTHER] += 1;
            if (last_cond == itp_pkg::COND_WRITES && is_branch &&
                b.cond_kind == itp_pkg::COND_READS)
               scalar_count[itp_pkg::SC_FUSE] += 1;
            last_cond = b.cond_kind;
         end
         itp_pkg::OP_READ: begin
            value = '0;
            if (b.read_table == itp_pkg::TBL_SCALAR) begin
               if (b.read_index < NSC) value = scalar_count[b.read_index];
            end else if (b.read_index < BINS) begin
               case (b.read_table)
                  itp_pkg::TBL_MICRO: value = DW'(micro_bins[b.read_index]);
                  itp_pkg::TBL_SIZE:  value = DW'(size_bins[b.read_index]);
                  default:            value = DW'(branch_bins[b.read_index]);
               endcase
            end
            expected_read_data.push_back(value);
         end
         itp_pkg::OP_FLUSH: begin
            micro_bins[clamp_bin(64'(last_micro))] += 1;
            last_micro = '0;
         end
         default: ;
      endcase
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic trace_beat_type random_beat();
      trace_beat_type b;
      b.op             = 2'($urandom_range(0, 3));
      b.micro_index    = 7'($urandom_range(0, 127));
      b.instr_address  = random_word();
      b.fallthrough_pc = random_word();
      b.branch_target  = random_word();
      b.cond_kind      = 2'($urandom_range(0, 3));
      b.mem_kind       = 2'($urandom_range(0, 3));
      b.read_table     = 2'($urandom_range(0, 3));
      b.read_index     = 7'($urandom_range(0, 127));
      return b;
   endfunction

   function automatic void push_record(input logic [6:0] micro, input logic [63:0] addr,
                                       input logic [63:0] fall, input logic [63:0] target,
                                       input logic [1:0] cond, input logic [1:0] mem);
      trace_beat_type b;
      b                = random_beat();
      b.op             = itp_pkg::OP_RECORD;
      b.micro_index    = micro;
      b.instr_address  = addr;
      b.fallthrough_pc = fall;
      b.branch_target  = target;
      b.cond_kind      = cond;
      b.mem_kind       = mem;
      pending_beats.push_back(b);
   endfunction

   function automatic void push_simple(input logic [1:0] op, input logic [1:0] tbl,
                                       input logic [6:0] index);
      trace_beat_type b;
      b            = random_beat();
      b.op         = op;
      b.read_table = tbl;
      b.read_index = index;
      pending_beats.push_back(b);
   endfunction

   function automatic void push_random_read();
      logic [1:0] tbl;
      int         pick;
      logic [6:0] index;
      tbl  = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      if (tbl == itp_pkg::TBL_SCALAR)
         index = (pick < 8) ? 7'($urandom_range(0, NSC - 1)) :
                 7'($urandom_range(NSC, 127));
      else if (pick < 6)
         index = 7'($urandom_range(0, 20));
      else if (pick < 8)
         index = 7'($urandom_range(60, 70));
      else
         index = 7'($urandom_range(0, 127));
      push_simple(itp_pkg::OP_READ, tbl, index);
   endfunction

   function automatic void push_random_macro();
      int          count;
      int          pick;
      int          i;
      logic [63:0] addr;
      logic [63:0] size;
      logic [63:0] offset;
      logic [63:0] target;
      logic [1:0]  cond;
      logic [1:0]  mem;
      bit          branch_at_end;
      pick  = $urandom_range(0, 99);
      count = (pick < 2) ? $urandom_range(17, 127) :
              (pick < 10) ? $urandom_range(5, 16) : $urandom_range(1, 4);
      addr  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 4095)) : random_word();
      pick  = $urandom_range(0, 99);
      size  = (pick < 80) ? 64'($urandom_range(1, 15)) :
              (pick < 92) ? 64'($urandom_range(0, 200)) : random_word();
      branch_at_end = ($urandom_range(0, 9) < 4);
      offset = ($urandom_range(0, 19) == 0) ? '0 : random_word() >> $urandom_range(0, 63);
      target = $urandom_range(0, 1) ? addr + offset : addr - offset;
      for (i = 1; i <= count; i++) begin
         if (branch_at_end && i == count) begin
            pick = $urandom_range(0, 99);
            cond = (pick < 45) ? itp_pkg::COND_READS :
                   (pick < 80) ? itp_pkg::COND_NONE : 2'($urandom_range(0, 3));
            mem  = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : MEM_NONE;
            push_record(7'(i), addr, addr + size, target, cond, mem);
         end else begin
            cond = ($urandom_range(0, 9) < 4) ? itp_pkg::COND_WRITES :
                   2'($urandom_range(0, 3));
            mem  = 2'($urandom_range(0, 3));
            push_record(7'(i), addr, addr + size, '0, cond, mem);
         end
      end
   endfunction

   // Directed opening, then random macro-op streams mixed with reads and noise.
   initial begin
      int pick;
      for (int i = 0; i < BINS; i++) begin
         micro_bins[i]  = '0;
         size_bins[i]   = '0;
         branch_bins[i] = '0;
      end
      for (int i = 0; i < NSC; i++) scalar_count[i] = '0;
      last_micro     = '0;
      last_cond      = itp_pkg::COND_NONE;
      beats_accepted = 0;
      reads_checked  = 0;
      mismatches     = 0;
      burst_left     = 0;
      gap_left       = 0;
      stall_mode     = 0;
      stall_phase_left = 0;
      idle_cycles    = 0;

      push_simple(itp_pkg::OP_READ, itp_pkg::TBL_MICRO, 7'd0);
      push_record(7'd1, 64'h1000, 64'h1004, '0, itp_pkg::COND_WRITES, MEM_NONE);
      push_record(7'd2, 64'h1000, 64'h1004, 64'h1000, itp_pkg::COND_READS, MEM_NONE);
      push_record(7'd1, '1, '0, '0, itp_pkg::COND_NONE, MEM_NONE);
      push_record(7'd2, '0, 64'h4, '1, itp_pkg::COND_NONE, itp_pkg::MEM_LOAD);
      push_record(7'd1, 64'h2000, 64'h1FF0, '0, COND_OTHER, itp_pkg::MEM_STORE);
      push_record(7'd127, 64'h2000, 64'h1FF0, '0, COND_OTHER, MEM_SPARE);
      push_record(7'd1, 64'h3000, 64'h3080, '0, itp_pkg::COND_NONE, MEM_NONE);
      push_record(7'd0, 64'h3000, 64'h3080, '0, itp_pkg::COND_NONE, MEM_NONE);
      push_record(7'd1, 64'h4000, 64'h407F, '0, itp_pkg::COND_WRITES, MEM_NONE);
      push_record(7'd1, 64'h5000, 64'h5002, 64'h5001, itp_pkg::COND_NONE, MEM_NONE);
      push_simple(itp_pkg::OP_FLUSH, itp_pkg::TBL_MICRO, 7'd0);
      push_simple(itp_pkg::OP_FLUSH, itp_pkg::TBL_MICRO, 7'd0);
      push_simple(OP_SPARE, itp_pkg::TBL_SCALAR, 7'd0);
      push_simple(itp_pkg::OP_READ, itp_pkg::TBL_MICRO, 7'd0);
      push_simple(itp_pkg::OP_READ, itp_pkg::TBL_MICRO, 7'd127);
      push_simple(itp_pkg::OP_READ, itp_pkg::TBL_SIZE, 7'd4);
      push_simple(itp_pkg::OP_READ, itp_pkg::TBL_SIZE, 7'd127);
      push_simple(itp_pkg::OP_READ, itp_pkg::TBL_BRANCH, 7'd0);
      push_simple(itp_pkg::OP_READ, itp_pkg::TBL_BRANCH, 7'd65);
      push_simple(itp_pkg::OP_READ, itp_pkg::TBL_BRANCH, 7'd2);
      push_simple(itp_pkg::OP_READ, itp_pkg::TBL_SCALAR, 7'(itp_pkg::SC_SIZE));
      push_simple(itp_pkg::OP_READ, itp_pkg::TBL_SCALAR, 7'(itp_pkg::SC_FUSE));
      push_simple(itp_pkg::OP_READ, itp_pkg::TBL_SCALAR, 7'(NSC));
      push_simple(itp_pkg::OP_READ, itp_pkg::TBL_SCALAR, 7'd127);

      while (pending_beats.size() < RANDOM_BEATS + 25) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) push_random_macro();
         else if (pick < 82) push_random_read();
         else if (pick < 87) push_simple(itp_pkg::OP_FLUSH, 2'($urandom_range(0, 3)),
                                         7'($urandom_range(0, 127)));
         else if (pick < 89) push_simple(OP_SPARE, 2'($urandom_range(0, 3)),
                                         7'($urandom_range(0, 127)));
         else pending_beats.push_back(random_beat());
      end
      for (int i = 0; i < NSC; i++) push_simple(itp_pkg::OP_READ, itp_pkg::TBL_SCALAR, 7'(i));
      total_beats = pending_beats.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (beats_accepted < total_beats) @(posedge clock);
      while (expected_read_data.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request beats and %0d checked read beats.",
               beats_accepted, reads_checked);
      $display("Profiled %0d macro-ops, %0d branches and %0d fusion pairs.",
               scalar_count[itp_pkg::SC_MACRO], scalar_count[itp_pkg::SC_BRANCH],
               scalar_count[itp_pkg::SC_FUSE]);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            profile_beat(current_beat);
            beats_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               current_beat = pending_beats.pop_front();
               req_op             <= current_beat.op;
               req_micro_index    <= current_beat.micro_index;
               req_instr_address  <= current_beat.instr_address;
               req_fallthrough_pc <= current_beat.fallthrough_pc;
               req_branch_target  <= current_beat.branch_target;
               req_cond_kind      <= current_beat.cond_kind;
               req_mem_kind       <= current_beat.mem_kind;
               req_read_table     <= current_beat.read_table;
               req_read_index     <= current_beat.read_index;
               req_valid          <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  gap_left   = $urandom_range(1, 8);
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) :
                               $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      logic [DW-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            reads_checked++;
            if (expected_read_data.size() == 0) begin
               $error("read_data beat with no pending read: expected none, actual %h",
                      rsp_read_data);
               mismatches++;
            end else begin
               want = expected_read_data.pop_front();
               if (rsp_read_data !== want) begin
                  $error("read_data mismatch: expected %h, actual %h", want, rsp_read_data);
                  mismatches++;
               end
            end
         end
         if (stall_phase_left == 0) begin
            stall_mode       = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(10, 120);
         end else begin
            stall_phase_left--;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 7) != 0);
            default: rsp_ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

endmodule

// ===== instruction_trace_profiler_core.f =====
hw/rtl/itp_pkg.sv
hw/rtl/itp_hist_bank.sv
hw/rtl/itp_rsp_fifo.sv
hw/rtl/itp_front.sv
hw/rtl/instruction_trace_profiler_core.sv
sim/tb_instruction_trace_profiler_core.sv
